>>> src/iqsw_pkg.sv
// ----------------------------------------------------------------------------
// iqsw_pkg
// Shared widths, register map and slot result type for the input-queued
// switch head-of-line arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package iqsw_pkg;

    // payload field widths
    localparam int FIELD_PORTS = 8;
    localparam int DEST_W      = 3;
    localparam int MASK_W      = FIELD_PORTS;
    localparam int DESTS_W     = FIELD_PORTS * DEST_W;
    localparam int COUNT_W     = 4;
    localparam int TOTAL_W     = 32;

    // configuration register map
    localparam int CFG_W       = 4;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int REG_IDX_W   = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_PORTS_IN_USE = 1'b0;
    localparam logic [CFG_W-1:0]     PORTS_IN_USE_RST = 4'd8;

    typedef struct packed {
        logic [MASK_W-1:0]  grant;
        logic [MASK_W-1:0]  busy;
        logic [COUNT_W-1:0] count;
        logic [MASK_W-1:0]  bad;
    } slot_res_t;

endpackage

`default_nettype wire

>>> src/iqsw_in_if.sv
// ----------------------------------------------------------------------------
// iqsw_in_if
// Time slot channel: arrival mask and packed new head destinations.
// ----------------------------------------------------------------------------
`default_nettype none

interface iqsw_in_if;

    logic                         valid;
    logic                         ready;
    logic [iqsw_pkg::MASK_W-1:0]  arrival_mask;
    logic [iqsw_pkg::DESTS_W-1:0] arrival_destinations;

    modport source (
        output valid,
        input  ready,
        output arrival_mask,
        output arrival_destinations
    );

    modport sink (
        input  valid,
        output ready,
        input  arrival_mask,
        input  arrival_destinations
    );

endinterface

`default_nettype wire

>>> src/iqsw_out_if.sv
// ----------------------------------------------------------------------------
// iqsw_out_if
// Slot result channel: grants, busy outputs, counts and dropped arrivals.
// ----------------------------------------------------------------------------
`default_nettype none

interface iqsw_out_if;

    logic                         valid;
    logic                         ready;
    logic [iqsw_pkg::MASK_W-1:0]  input_grant_mask;
    logic [iqsw_pkg::MASK_W-1:0]  output_busy_mask;
    logic [iqsw_pkg::COUNT_W-1:0] slot_sent;
    logic [iqsw_pkg::TOTAL_W-1:0] total_sent;
    logic [iqsw_pkg::MASK_W-1:0]  bad_destination_mask;

    modport source (
        output valid,
        input  ready,
        output input_grant_mask,
        output output_busy_mask,
        output slot_sent,
        output total_sent,
        output bad_destination_mask
    );

    modport sink (
        input  valid,
        output ready,
        input  input_grant_mask,
        input  output_busy_mask,
        input  slot_sent,
        input  total_sent,
        input  bad_destination_mask
    );

endinterface

`default_nettype wire

>>> src/iqsw_slot.sv
// ----------------------------------------------------------------------------
// iqsw_slot
// One time slot of the crossbar: fills empty heads from arrivals, then grants
// each output to the lowest-numbered eligible input asking for it.
// ----------------------------------------------------------------------------
`default_nettype none

module iqsw_slot #(
    parameter int PORTS = 8,
    parameter int N_W   = 4
) (
    input  wire logic [PORTS-1:0]                  head_occ,
    input  wire logic [PORTS-1:0][iqsw_pkg::DEST_W-1:0] head_dest,
    input  wire logic [N_W-1:0]                    n_active,
    input  wire logic [iqsw_pkg::MASK_W-1:0]       arrival_mask,
    input  wire logic [iqsw_pkg::DESTS_W-1:0]      arrival_destinations,
    output logic      [PORTS-1:0]                  head_occ_next,
    output logic      [PORTS-1:0][iqsw_pkg::DEST_W-1:0] head_dest_next,
    output iqsw_pkg::slot_res_t                    res
);
    import iqsw_pkg::*;

    localparam int CMP_W = (N_W > DEST_W) ? N_W : DEST_W;

    logic [PORTS-1:0]             arrive;
    logic [PORTS-1:0]             bad;
    logic [PORTS-1:0]             occ1;
    logic [PORTS-1:0][DEST_W-1:0] dest1;
    logic [PORTS-1:0]             elig;
    logic [PORTS-1:0]             grant;
    logic [MASK_W-1:0]            busy;
    logic [COUNT_W-1:0]           cnt;

    for (genvar i = 0; i < PORTS; i++) begin : g_port
        localparam logic [N_W-1:0] IDX = N_W'(i);
        logic              act;
        logic              arr_bit;
        logic [DEST_W-1:0] new_dest;

        assign act = IDX < n_active;

        // ports beyond the payload fields never see arrivals
        if (i < FIELD_PORTS) begin : g_field
            assign arr_bit  = arrival_mask[i];
            assign new_dest = arrival_destinations[DEST_W*i +: DEST_W];
        end
        else begin : g_nofield
            assign arr_bit  = 1'b0;
            assign new_dest = '0;
        end

        assign arrive[i] = act && !head_occ[i] && arr_bit;
        assign bad[i]    = arrive[i] && (CMP_W'(new_dest) >= CMP_W'(n_active));
        assign occ1[i]   = head_occ[i] || (arrive[i] && !bad[i]);
        assign dest1[i]  = (arrive[i] && !bad[i]) ? new_dest : head_dest[i];
        // stale heads pointing past the active range stay parked
        assign elig[i]   = act && occ1[i] && (CMP_W'(dest1[i]) < CMP_W'(n_active));
    end

    // fixed priority: a lower input asking for the same output wins
    always_comb
    begin
        grant = elig;
        for (int i = 1; i < PORTS; i++)
        begin
            for (int j = 0; j < i; j++)
            begin
                if (elig[j] && (dest1[j] == dest1[i]))
                begin
                    grant[i] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        busy = '0;
        for (int i = 0; i < PORTS; i++)
        begin
            if (grant[i])
            begin
                busy[dest1[i]] = 1'b1;
            end
        end
    end

    // one packet per busy output
    always_comb
    begin
        cnt = '0;
        for (int k = 0; k < MASK_W; k++)
        begin
            cnt = cnt + COUNT_W'(busy[k]);
        end
    end

    assign head_occ_next  = occ1 & ~grant;
    assign head_dest_next = dest1;

    for (genvar k = 0; k < MASK_W; k++) begin : g_mask
        if (k < PORTS) begin : g_live
            assign res.grant[k] = grant[k];
            assign res.bad[k]   = bad[k];
        end
        else begin : g_pad
            assign res.grant[k] = 1'b0;
            assign res.bad[k]   = 1'b0;
        end
    end

    assign res.busy  = busy;
    assign res.count = cnt;

endmodule

`default_nettype wire

>>> src/input_queued_switch_hol_arbiter_unit.sv
// an accepted slot passes the input register and the result register before it shows on out_ch
// throughput: one time slot per cycle while out_ch is not stalled, set by the single-pass slot logic
//   between the input register and the result register
// a slot is taken while a finished result waits, the input register parts them
// reset: all heads empty, running total zero, ports_in_use back to 8
// ----------------------------------------------------------------------------
// input_queued_switch_hol_arbiter_unit
// Input-queued crossbar scheduler with head-of-line blocking and fixed
// priority, APB configuration and valid/ready slot channels.
// ----------------------------------------------------------------------------
`default_nettype none

module input_queued_switch_hol_arbiter_unit #(
    parameter int PORTS = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [iqsw_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [iqsw_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [iqsw_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    iqsw_in_if.sink                              in_ch,
    iqsw_out_if.source                           out_ch
);
    import iqsw_pkg::*;

    localparam int N_W     = $clog2(PORTS + 1);
    localparam int CLAMP_W = (N_W > CFG_W) ? N_W : CFG_W;

    logic [CFG_W-1:0]   ports_in_use_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [CLAMP_W-1:0] cfg_ext;
    logic [N_W-1:0]     n_active;

    logic               s1_valid_reg;
    logic [MASK_W-1:0]  s1_mask_reg;
    logic [DESTS_W-1:0] s1_dests_reg;
    logic               advance;

    logic [PORTS-1:0]             head_occ_reg;
    logic [PORTS-1:0][DEST_W-1:0] head_dest_reg;
    logic [PORTS-1:0]             head_occ_next;
    logic [PORTS-1:0][DEST_W-1:0] head_dest_next;
    slot_res_t                    slot_res;

    logic               out_valid_reg;
    slot_res_t          res_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic [TOTAL_W:0]   total_sum;

    // register file
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ports_in_use_reg <= PORTS_IN_USE_RST;
        end
        else if (psel && penable && pwrite && pready && (reg_idx == REG_PORTS_IN_USE))
        begin
            ports_in_use_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_PORTS_IN_USE)
        begin
            prdata = APB_DATA_W'(ports_in_use_reg);
        end
    end

    // zero acts as one, anything past PORTS acts as PORTS
    assign cfg_ext = CLAMP_W'(ports_in_use_reg);

    always_comb
    begin
        priority if (ports_in_use_reg == '0)
        begin
            n_active = N_W'(1);
        end
        else if (cfg_ext > CLAMP_W'(PORTS))
        begin
            n_active = N_W'(PORTS);
        end
        else
        begin
            n_active = N_W'(cfg_ext);
        end
    end

    // slot pipeline
    assign advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_mask_reg  <= in_ch.arrival_mask;
            s1_dests_reg <= in_ch.arrival_destinations;
        end
    end

    iqsw_slot #(
        .PORTS (PORTS),
        .N_W   (N_W)
    ) u_slot (
        .head_occ             (head_occ_reg),
        .head_dest            (head_dest_reg),
        .n_active             (n_active),
        .arrival_mask         (s1_mask_reg),
        .arrival_destinations (s1_dests_reg),
        .head_occ_next        (head_occ_next),
        .head_dest_next       (head_dest_next),
        .res                  (slot_res)
    );

    // saturating running total
    assign total_sum  = {1'b0, total_reg} + (TOTAL_W + 1)'(slot_res.count);
    assign total_next = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_occ_reg  <= '0;
            head_dest_reg <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                head_occ_reg  <= head_occ_next;
                head_dest_reg <= head_dest_next;
                total_reg     <= total_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= slot_res;
        end
    end

    assign out_ch.valid                = out_valid_reg;
    assign out_ch.input_grant_mask     = res_reg.grant;
    assign out_ch.output_busy_mask     = res_reg.busy;
    assign out_ch.slot_sent            = res_reg.count;
    assign out_ch.total_sent           = total_reg;
    assign out_ch.bad_destination_mask = res_reg.bad;

endmodule

`default_nettype wire

>>> src/iqsw_checker.sv
// ----------------------------------------------------------------------------
// iqsw_checker
// Port-level checks on the slot result channel of the switch arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

module iqsw_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         out_valid,
    input  wire logic                         out_ready,
    input  wire logic [iqsw_pkg::MASK_W-1:0]  input_grant_mask,
    input  wire logic [iqsw_pkg::MASK_W-1:0]  output_busy_mask,
    input  wire logic [iqsw_pkg::COUNT_W-1:0] slot_sent,
    input  wire logic [iqsw_pkg::TOTAL_W-1:0] total_sent,
    input  wire logic [iqsw_pkg::MASK_W-1:0]  bad_destination_mask
);
    import iqsw_pkg::*;

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(total_sent)
            && $stable(input_grant_mask) && $stable(slot_sent))
        else $error("result changed while stalled");

    // every grant lands on a distinct output
    a_grant_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones(input_grant_mask) == $countones(output_busy_mask))
        else $error("grant and busy masks disagree");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones(output_busy_mask) == int'(slot_sent))
        else $error("slot count does not match busy outputs");

    // a dropped arrival leaves an empty head, which cannot send
    a_bad_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (input_grant_mask & bad_destination_mask) == '0)
        else $error("port granted in the slot its arrival was dropped");

    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> total_sent >= TOTAL_W'(slot_sent))
        else $error("running total below this slot's count");

endmodule

bind input_queued_switch_hol_arbiter_unit iqsw_checker u_iqsw_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .input_grant_mask     (out_ch.input_grant_mask),
    .output_busy_mask     (out_ch.output_busy_mask),
    .slot_sent            (out_ch.slot_sent),
    .total_sent           (out_ch.total_sent),
    .bad_destination_mask (out_ch.bad_destination_mask)
);

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the input-queued switch head-of-line arbiter.
// Slots go in through the input channel. A behavioral scheduler in the bench
// predicts each slot result, and the output channel is checked against it.
// ports_in_use is reprogrammed over APB between traffic phases, and both
// channels are throttled with random stall bursts.
// ----------------------------------------------------------------------------

module tb;
    import iqsw_pkg::*;

    typedef struct packed {
        slot_res_t          res;
        logic [TOTAL_W-1:0] total;
    } slot_expect_t;

    localparam logic [APB_ADDR_W-1:0] ADDR_PORTS_IN_USE = {REG_PORTS_IN_USE, 2'b00};
    localparam int SLOTS_PER_PHASE = 132;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    iqsw_in_if  in_ch ();
    iqsw_out_if out_ch ();

    input_queued_switch_hol_arbiter_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #5 clk = ~clk;

    // scheduler state mirrored in the bench
    logic [CFG_W-1:0]       ports_cfg;
    logic [DEST_W-1:0]      hol_dest [FIELD_PORTS];
    logic [FIELD_PORTS-1:0] hol_full;
    logic [TOTAL_W-1:0]     switched_total;
    slot_expect_t           pending_slots [$];

    int mismatch_count;
    bit idle_on;
    int stall_left;

    function automatic int active_ports();
        if (ports_cfg == '0)
            return 1;
        if (ports_cfg > FIELD_PORTS)
            return FIELD_PORTS;
        return int'(ports_cfg);
    endfunction

    function automatic void schedule_slot(input logic [MASK_W-1:0]  arrivals,
                                          input logic [DESTS_W-1:0] dests);
        slot_expect_t      e;
        int                n;
        int                i;
        logic [DEST_W-1:0] d;
        logic [COUNT_W-1:0] cnt;
        n   = active_ports();
        e   = '0;
        cnt = '0;
        // arrivals only land on empty active heads
        for (i = 0; i < n; i++)
        begin
            if (!hol_full[i] && arrivals[i])
            begin
                d = dests[DEST_W*i +: DEST_W];
                if (d >= n)
                    e.res.bad[i] = 1'b1;
                else
                begin
                    hol_dest[i] = d;
                    hol_full[i] = 1'b1;
                end
            end
        end
        // fixed priority, lowest input wins; stale heads are skipped
        for (i = 0; i < n; i++)
        begin
            if (hol_full[i] && hol_dest[i] < n && !e.res.busy[hol_dest[i]])
            begin
                e.res.busy[hol_dest[i]] = 1'b1;
                e.res.grant[i]          = 1'b1;
                hol_full[i]             = 1'b0;
                cnt++;
            end
        end
        if (switched_total > {TOTAL_W{1'b1}} - cnt)
            switched_total = {TOTAL_W{1'b1}};
        else
            switched_total = switched_total + cnt;
        e.res.count = cnt;
        e.total     = switched_total;
        pending_slots.push_back(e);
    endfunction

    function automatic void compare_slot_result();
        slot_expect_t e;
        if (pending_slots.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: slot result with nothing pending: grant %h busy %h",
                         $realtime, out_ch.input_grant_mask, out_ch.output_busy_mask);
            return;
        end
        e = pending_slots.pop_front();
        if (out_ch.input_grant_mask !== e.res.grant || out_ch.output_busy_mask !== e.res.busy
            || out_ch.slot_sent !== e.res.count || out_ch.total_sent !== e.total
            || out_ch.bad_destination_mask !== e.res.bad)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: exp/act grant %h/%h busy %h/%h cnt %0d/%0d tot %0d/%0d bad %h/%h",
                         $realtime,
                         e.res.grant, out_ch.input_grant_mask, e.res.busy,
                         out_ch.output_busy_mask, e.res.count, out_ch.slot_sent,
                         e.total, out_ch.total_sent, e.res.bad,
                         out_ch.bad_destination_mask);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                schedule_slot(in_ch.arrival_mask, in_ch.arrival_destinations);
            if (out_ch.valid && out_ch.ready)
                compare_slot_result();
        end
    end

    // result side backpressure
    initial
    begin
        out_ch.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (idle_on && stall_left > 0)
            begin
                out_ch.ready = 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ch.ready = 1'b0;
                stall_left   = $urandom_range(1, 9) - 1;
            end
            else
                out_ch.ready = 1'b1;
        end
    end

    task automatic send_slot(input logic [MASK_W-1:0]  arrivals,
                             input logic [DESTS_W-1:0] dests);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 9);
        repeat (gap)
        begin
            @(negedge clk);
            in_ch.valid = 1'b0;
        end
        @(negedge clk);
        in_ch.valid                = 1'b1;
        in_ch.arrival_mask         = arrivals;
        in_ch.arrival_destinations = dests;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_slots.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
                            output logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic check_ports_readback(input logic [CFG_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        apb_read(ADDR_PORTS_IN_USE, rd);
        if (rd !== APB_DATA_W'(value))
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: ports_in_use read back %h, expected %h",
                         $realtime, rd, value);
        end
    endtask

    task automatic set_ports_in_use(input logic [CFG_W-1:0] value);
        wait_drain();
        apb_write(ADDR_PORTS_IN_USE, APB_DATA_W'(value));
        ports_cfg = value;
        check_ports_readback(value);
    endtask

    task automatic test_reset_value();
        check_ports_readback(PORTS_IN_USE_RST);
    endtask

    task automatic test_basic_slots();
        send_slot(8'h00, 24'o00000000);
        // one packet per output, no contention
        send_slot(8'hFF, 24'o76543210);
        // everyone wants output 0
        send_slot(8'hFF, 24'o00000000);
        // arrivals on blocked heads are ignored
        send_slot(8'hFF, 24'o76543210);
        repeat (7) send_slot(8'h00, 24'o00000000);
        send_slot(8'hFF, 24'o77777777);
        send_slot(8'h00, 24'o77777777);
    endtask

    task automatic test_port_limits();
        // heads 2..7 still hold output 7, which goes stale here
        set_ports_in_use(4'd3);
        send_slot(8'hFF, 24'o76543210);
        send_slot(8'h03, 24'o00000053);
        send_slot(8'hFF, 24'o22222222);
        // zero behaves as a single port
        set_ports_in_use(4'd0);
        send_slot(8'hFF, 24'o00000000);
        send_slot(8'h01, 24'o00000001);
        // values above the port count behave as all ports
        set_ports_in_use(4'd15);
        send_slot(8'h00, 24'o00000000);
        send_slot(8'h00, 24'o00000000);
        send_slot(8'hFF, 24'o01234567);
        set_ports_in_use(4'd8);
    endtask

    task automatic test_random_traffic();
        int               plan [14];
        int               p;
        int               k;
        int               i;
        int               n;
        int               style;
        bit               hot;
        int               hot_d;
        logic [MASK_W-1:0]  arrivals;
        logic [DESTS_W-1:0] dests;
        plan = '{1, 0, 15, 5, 2, 8, 9, 3, 7, 4, 6, 12, 8, 8};
        for (p = 0; p < 14; p++)
        begin
            set_ports_in_use(4'(plan[p]));
            idle_on = !(p == 3 || p == 8 || p >= 12);
            n = active_ports();
            for (k = 0; k < SLOTS_PER_PHASE; k++)
            begin
                style = $urandom_range(0, 9);
                if (style <= 5)
                    arrivals = MASK_W'($urandom_range(0, 255));
                else if (style <= 7)
                    arrivals = 8'hFF;
                else if (style == 8)
                    arrivals = 8'h01 << $urandom_range(0, 7);
                else
                    arrivals = MASK_W'($urandom_range(0, 255) & $urandom_range(0, 255));
                // mostly legal destinations, some hotspots, some out of range
                hot   = ($urandom_range(0, 4) == 0);
                hot_d = $urandom_range(0, n - 1);
                for (i = 0; i < FIELD_PORTS; i++)
                begin
                    if (hot)
                        dests[DEST_W*i +: DEST_W] = DEST_W'(hot_d);
                    else if ($urandom_range(0, 9) < 8)
                        dests[DEST_W*i +: DEST_W] = DEST_W'($urandom_range(0, n - 1));
                    else
                        dests[DEST_W*i +: DEST_W] = DEST_W'($urandom_range(0, 7));
                end
                send_slot(arrivals, dests);
            end
        end
    endtask

    initial
    begin
        rst_n                      = 1'b0;
        psel                       = 1'b0;
        penable                    = 1'b0;
        pwrite                     = 1'b0;
        paddr                      = '0;
        pwdata                     = '0;
        in_ch.valid                = 1'b0;
        in_ch.arrival_mask         = '0;
        in_ch.arrival_destinations = '0;
        ports_cfg                  = PORTS_IN_USE_RST;
        hol_full                   = '0;
        for (int i = 0; i < FIELD_PORTS; i++)
            hol_dest[i] = '0;
        switched_total = '0;
        mismatch_count = 0;
        idle_on        = 1'b1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_value();
        test_basic_slots();
        test_port_limits();
        test_random_traffic();
        wait_drain();

        if (mismatch_count == 0 && pending_slots.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
